FILE: rtl/bresenham_line_pixel_generator_assert.svh
// Assertion macros used by the back-stage RTL module.
// All checks are sampled on aclk and disabled while aresetn is low.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_ASSERT_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_ASSERT_SVH

// Same-cycle implication check.
`define BLPG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("blpg assertion failed");

// Next-cycle implication check.
`define BLPG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("blpg assertion failed");

`endif

FILE: rtl/blpg_pkg.sv
package blpg_pkg;

    localparam int COORD_BITS  = 13;
    localparam int DELTA_BITS  = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 2;
    localparam int DIM_BITS    = 12;
    localparam int COLOUR_BITS = 16;
    localparam int CMP_BITS    = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    localparam int S_TDATA_BITS = ((4 * COORD_BITS + COLOUR_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * COORD_BITS + COLOUR_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd320;
    localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd240;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [DELTA_BITS-1:0] delta_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic        [DIM_BITS-1:0]   dim_t;
    typedef logic        [COLOUR_BITS-1:0] colour_t;

    typedef struct packed {
        cmd_t    cmd;
        coord_t  major_start;
        coord_t  minor_start;
        coord_t  major_end;
        delta_t  delta_major;
        delta_t  delta_minor;
        logic    step_down;
        logic    steep;
        colour_t colour;
    } line_cmd_t;

endpackage

FILE: rtl/bresenham_line_pixel_generator.sv
// Bresenham line rasterizer with a stream input and a stream output.
// A slave transaction with s_tuser low loads a line: both endpoints and the
// colour travel in s_tdata, and no pixel results. A transaction with s_tuser
// high requests the next pixel of the current line; with no line loaded it
// is consumed and produces nothing. Each pixel leaves as one master
// transaction carrying its coordinates and colour in m_tdata, the visible
// flag in m_tuser, and m_tlast on the final pixel of the line.
// The screen size is set through the write port; the user must change it
// only while the block is idle, and the block itself does not enforce this.
// The front stage decodes each transaction and writes it into a two-entry
// command queue. The back stage takes each one from the queue and registers
// its pixel onto the master port. With m_tready high the block sustains
// one transaction per clock, limited by the back stage's single error-term update.
// When the receiver stalls, the held pixel stays on the master port while
// the queue fills; s_tready drops once both queue entries are occupied.
// Synchronous reset empties the queue, drops any line in progress and sets
// the screen to 320 by 240.
module bresenham_line_pixel_generator (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // start_x, start_y, end_x, end_y, colour, zero padding
    input  logic [blpg_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // command
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pixel_x, pixel_y, pixel_colour, zero padding
    output logic [blpg_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // visible
    output logic                                  m_tuser,
    output logic                                  m_tlast,
    input  logic                                  cfg_wr_en,
    input  logic [blpg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [blpg_pkg::DIM_BITS-1:0]         cfg_data
);
    import blpg_pkg::*;

    dim_t      screen_width_reg, screen_height_reg;
    logic      q_full, q_push, q_pop, q_head_valid;
    line_cmd_t q_entry, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    blpg_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    blpg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    blpg_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_head_valid),
        .head_entry    (q_head),
        .pop           (q_pop),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule

FILE: rtl/blpg_front.sv
module blpg_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_x, start_y, end_x, end_y, colour, zero padding
    input  logic [blpg_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // command
    input  logic                               s_tuser,
    input  logic                               q_full,
    output logic                               q_push,
    output blpg_pkg::line_cmd_t                q_entry
);
    import blpg_pkg::*;

    coord_t ax, ay, bx, by;
    logic signed [DELTA_BITS-1:0] dx, dy;
    delta_t adx, ady;
    logic   steep, swap;
    coord_t pa_maj, pa_min, pb_maj, pb_min;

    assign ax = s_tdata[COORD_BITS-1:0];
    assign ay = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign bx = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign by = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    always_comb begin
        dx  = DELTA_BITS'(bx) - DELTA_BITS'(ax);
        dy  = DELTA_BITS'(by) - DELTA_BITS'(ay);
        adx = dx[DELTA_BITS-1] ? delta_t'(-dx) : delta_t'(dx);
        ady = dy[DELTA_BITS-1] ? delta_t'(-dy) : delta_t'(dy);
        steep = ady > adx;
        swap  = steep ? (ay > by) : (ax > bx);
        pa_maj = steep ? ay : ax;
        pa_min = steep ? ax : ay;
        pb_maj = steep ? by : bx;
        pb_min = steep ? bx : by;

        q_entry.cmd         = cmd_t'(s_tuser);
        q_entry.major_start = swap ? pb_maj : pa_maj;
        q_entry.minor_start = swap ? pb_min : pa_min;
        q_entry.major_end   = swap ? pa_maj : pb_maj;
        q_entry.delta_major = steep ? ady : adx;
        q_entry.delta_minor = steep ? adx : ady;
        q_entry.step_down   = swap ? (pb_min >= pa_min) : (pa_min >= pb_min);
        q_entry.steep       = steep;
        q_entry.colour      = s_tdata[4*COORD_BITS+COLOUR_BITS-1:4*COORD_BITS];
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

FILE: rtl/blpg_queue.sv
module blpg_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  blpg_pkg::line_cmd_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output blpg_pkg::line_cmd_t head_entry
);
    import blpg_pkg::*;

    line_cmd_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;

    assign full       = count_reg == QCNT_BITS'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/blpg_back.sv
module blpg_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               head_valid,
    input  blpg_pkg::line_cmd_t                head_entry,
    output logic                               pop,
    input  blpg_pkg::dim_t                     screen_width,
    input  blpg_pkg::dim_t                     screen_height,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pixel_x, pixel_y, pixel_colour, zero padding
    output logic [blpg_pkg::M_TDATA_BITS-1:0]  m_tdata,
    // visible
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import blpg_pkg::*;

    `include "bresenham_line_pixel_generator_assert.svh"

    coord_t  major_pos_reg, major_pos_next;
    coord_t  minor_pos_reg, minor_pos_next;
    coord_t  major_end_reg;
    err_t    error_reg, error_next;
    delta_t  delta_major_reg;
    delta_t  delta_minor_reg;
    logic    step_down_reg;
    logic    steep_reg;
    colour_t colour_reg;
    logic    active_reg, active_next;

    logic    m_tvalid_reg, m_tvalid_next;
    coord_t  px_reg, py_reg;
    colour_t out_colour_reg;
    logic    visible_reg, last_reg;

    logic    out_free, is_load, is_step, fire, fin, vis;
    coord_t  px, py;
    err_t    err_sub;

    always_comb begin
        out_free = !m_tvalid_reg || m_tready;
        is_load  = head_valid && head_entry.cmd == CMD_LOAD;
        is_step  = head_valid && head_entry.cmd == CMD_STEP;
        fire     = is_step && active_reg && out_free;
        pop      = is_load || (is_step && !active_reg) || fire;

        px  = steep_reg ? minor_pos_reg : major_pos_reg;
        py  = steep_reg ? major_pos_reg : minor_pos_reg;
        vis = !px[COORD_BITS-1] && !py[COORD_BITS-1] &&
              (CMP_BITS'($unsigned(px)) < CMP_BITS'(screen_width)) &&
              (CMP_BITS'($unsigned(py)) < CMP_BITS'(screen_height));
        fin = major_pos_reg >= major_end_reg;

        err_sub        = error_reg - $signed({1'b0, delta_minor_reg});
        error_next     = error_reg;
        minor_pos_next = minor_pos_reg;
        major_pos_next = major_pos_reg;
        active_next    = active_reg;
        if (fire) begin
            if (fin) begin
                active_next = 1'b0;
            end else begin
                error_next     = err_sub;
                major_pos_next = major_pos_reg + 1'b1;
                if (err_sub[ERR_BITS-1]) begin
                    error_next     = err_sub + $signed({1'b0, delta_major_reg});
                    minor_pos_next = step_down_reg ? minor_pos_reg - 1'b1
                                                   : minor_pos_reg + 1'b1;
                end
            end
        end

        m_tvalid_next = fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            active_reg   <= is_load ? 1'b1 : active_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_load) begin
            major_pos_reg   <= head_entry.major_start;
            minor_pos_reg   <= head_entry.minor_start;
            major_end_reg   <= head_entry.major_end;
            delta_major_reg <= head_entry.delta_major;
            delta_minor_reg <= head_entry.delta_minor;
            error_reg       <= $signed({1'b0, head_entry.delta_major >> 1});
            step_down_reg   <= head_entry.step_down;
            steep_reg       <= head_entry.steep;
            colour_reg      <= head_entry.colour;
        end else begin
            major_pos_reg <= major_pos_next;
            minor_pos_reg <= minor_pos_next;
            error_reg     <= error_next;
        end
        if (fire) begin
            px_reg         <= px;
            py_reg         <= py;
            out_colour_reg <= colour_reg;
            visible_reg    <= vis;
            last_reg       <= fin;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'({out_colour_reg, py_reg, px_reg});
    assign m_tuser  = visible_reg;
    assign m_tlast  = last_reg;

    `BLPG_ASSERT_IMP(a_pop_needs_head, pop, head_valid)
    `BLPG_ASSERT_IMP(a_error_nonneg, active_reg, !error_reg[ERR_BITS-1])
    `BLPG_ASSERT_NXT(a_last_ends_line, fire && fin && !is_load, !active_reg && m_tlast)
    `BLPG_ASSERT_NXT(a_major_advances, fire && !fin,
                     major_pos_reg == $past(major_pos_reg) + 1'b1)

endmodule
